/* hw/rtl/rda_pkg.sv */
// Shared types and codes for the base-N digit ALU.
// Used by rda_ctrl, rda_dp and radix_digit_alu_core; depends on nothing.
package rda_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] operand_a;
    logic [6:0] operand_b;
    logic [6:0] operand_high;
    logic       clear_carry;
  } req_t;

  typedef struct packed {
    logic [6:0] digit_result;
    logic [6:0] digit_extra;
    logic       carry_out;
    logic       error;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic rerun;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic more;
  } sts_t;

endpackage

/* hw/rtl/rda_ctrl.sv */
// Sequencer for the digit ALU: accepts a beat, runs the datapath passes,
// and owns the result valid flag. Depends on rda_pkg.
module rda_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rda_pkg::cmd_t  cmd,
  input  rda_pkg::sts_t  sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && req_valid;
    cmd.prep   = (state == ST_PREP);
    cmd.step   = (state == ST_DIV);
    cmd.rerun  = (state == ST_FIN) && sts.more;
    cmd.commit = (state == ST_FIN) && !sts.more && (!rsp_valid || !rsp_stall);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_valid) state_next = ST_PREP;
      ST_PREP: state_next = ST_DIV;
      ST_DIV:  if (sts.div_done) state_next = ST_FIN;
      ST_FIN: begin
        if (sts.more) begin
          state_next = ST_DIV;
        end else if (cmd.commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/rda_dp.sv */
// Datapath for the digit ALU: operand latch, carry flag, two-bit-per-cycle
// restoring divider and result register. Depends on rda_pkg.
module rda_dp #(
  parameter int DIGIT_BASE = 100
) (
  input  logic          clk,
  input  logic          rst,
  input  rda_pkg::req_t req,
  input  rda_pkg::cmd_t cmd,
  output rda_pkg::sts_t sts,
  output rda_pkg::rsp_t rsp
);

  localparam int BASE_W = $clog2(DIGIT_BASE + 1);
  localparam int DEN_W  = (BASE_W > 7) ? BASE_W : 7;
  localparam int RAW_W  = (7 + BASE_W > 14) ? 7 + BASE_W : 14;
  localparam int NUM_W  = RAW_W + (RAW_W % 2);
  localparam int STEPS  = NUM_W / 2;
  localparam int CNT_W  = $clog2(STEPS);
  localparam logic [DEN_W-1:0] BASE_D = DEN_W'(DIGIT_BASE);
  localparam logic [NUM_W-1:0] BASE_N = NUM_W'(DIGIT_BASE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  rda_pkg::op_t     op;
  logic [6:0]       opa;
  logic [6:0]       opb;
  logic [6:0]       ophi;
  logic             carry;
  logic             neg;
  logic             pass2;
  logic [6:0]       lo;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;

  logic [8:0]       sum;
  logic [8:0]       diff;
  logic [8:0]       mag;
  logic [NUM_W-1:0] dividend;

  logic [DEN_W:0]   den_x;
  logic [DEN_W:0]   sh1;
  logic [DEN_W:0]   sh2;
  logic             q1;
  logic             q2;
  logic [DEN_W-1:0] r1;
  logic [DEN_W-1:0] r2;

  rda_pkg::rsp_t    rsp_next;
  logic             carry_next;
  logic             bad_div;

  assign sum  = {2'b00, opa} + {2'b00, opb} + {8'd0, carry};
  assign diff = {2'b00, opa} - {2'b00, opb} - {8'd0, carry};
  assign mag  = diff[8] ? (~diff + 9'd1) : diff;

  always_comb begin
    case (op)
      rda_pkg::OP_ADD: dividend = NUM_W'(sum);
      rda_pkg::OP_SUB: dividend = NUM_W'(mag);
      rda_pkg::OP_MUL: dividend = NUM_W'(opa) * NUM_W'(opb);
      rda_pkg::OP_DIV: dividend = NUM_W'(ophi) * BASE_N + NUM_W'(opa);
      default:         dividend = '0;
    endcase
  end

  always_comb begin
    den_x = {1'b0, den};
    sh1   = {rem, num[NUM_W-1]};
    q1    = (sh1 >= den_x);
    r1    = q1 ? DEN_W'(sh1 - den_x) : sh1[DEN_W-1:0];
    sh2   = {r1, num[NUM_W-2]};
    q2    = (sh2 >= den_x);
    r2    = q2 ? DEN_W'(sh2 - den_x) : sh2[DEN_W-1:0];
  end

  assign sts.div_done = cmd.step && (cnt == CNT_LAST);
  assign sts.more     = (op == rda_pkg::OP_MUL) && !pass2;

  always_comb begin
    rsp_next   = '0;
    carry_next = carry;
    bad_div    = (opb == 7'd0) || (num >= BASE_N);
    case (op)
      rda_pkg::OP_ADD: begin
        rsp_next.digit_result = rem[6:0];
        carry_next            = |num;
      end
      rda_pkg::OP_SUB: begin
        if (neg && (rem != '0)) begin
          rsp_next.digit_result = 7'(BASE_D - rem);
        end else begin
          rsp_next.digit_result = rem[6:0];
        end
        carry_next = neg;
      end
      rda_pkg::OP_MUL: begin
        rsp_next.digit_result = lo;
        rsp_next.digit_extra  = rem[6:0];
      end
      rda_pkg::OP_DIV: begin
        if (bad_div) begin
          rsp_next.error = 1'b1;
        end else begin
          rsp_next.digit_result = rem[6:0];
          rsp_next.digit_extra  = num[6:0];
        end
      end
      default: rsp_next = '0;
    endcase
    rsp_next.carry_out = carry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= 1'b0;
    end else if (cmd.load && req.clear_carry) begin
      carry <= 1'b0;
    end else if (cmd.commit) begin
      carry <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= rda_pkg::op_t'(req.req_type);
      opa  <= req.operand_a;
      opb  <= req.operand_b;
      ophi <= req.operand_high;
    end
    if (cmd.prep) begin
      num   <= dividend;
      den   <= (op == rda_pkg::OP_DIV) ? DEN_W'(opb) : BASE_D;
      rem   <= '0;
      cnt   <= '0;
      pass2 <= 1'b0;
      neg   <= diff[8];
    end else if (cmd.step) begin
      num <= {num[NUM_W-3:0], q1, q2};
      rem <= r2;
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.rerun) begin
      lo    <= rem[6:0];
      rem   <= '0;
      cnt   <= '0;
      pass2 <= 1'b1;
    end
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* hw/rtl/radix_digit_alu_core.sv */
// Digit ALU, base DIGIT_BASE: add/sub with carry, multiply, two-digit divide.
// One beat in flight: req_stall stays high from acceptance until the result is
// committed, and the commit waits while a pending result is stalled. The
// two-bit-per-cycle restoring divider runs over NUM_W bits (NUM_W = 14 at base 100);
// multiply uses it twice.
// Reset clears the carry flag and the sequencer; no result is pending after it.
module radix_digit_alu_core #(
  parameter int DIGIT_BASE = 100
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rda_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rda_pkg::rsp_t rsp
);

  rda_pkg::cmd_t cmd;
  rda_pkg::sts_t sts;

  rda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rda_dp #(
    .DIGIT_BASE (DIGIT_BASE)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(rsp_valid && rsp_stall))
    else $error("result register overwritten while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second beat accepted while busy");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !req_stall |-> !(cmd.prep || cmd.step || cmd.rerun || cmd.commit))
    else $error("datapath command issued while idle");

endmodule

/* dv/radix_digit_alu_core_tb.sv */
// Self-checking bench for radix_digit_alu_core: directed table, then random idle/stall phases.
// Depends on rda_pkg and the core RTL; known rows are checked as given, others by the predictor.
module radix_digit_alu_core_tb;

  localparam int DIGIT_BASE = 100;

  typedef struct packed {
    rda_pkg::req_t op;
    logic          known;
    rda_pkg::rsp_t want;
  } row_t;

  // Fields: op, a, b, high, clear / known / result, extra, carry, error.
  localparam row_t DIRECTED[21] = '{
    '{'{rda_pkg::OP_ADD, 7'd0,   7'd0,   7'd0,   1'b0}, 1'b1, '{7'd0,  7'd0,  1'b0, 1'b0}},
    '{'{rda_pkg::OP_ADD, 7'd99,  7'd99,  7'd0,   1'b0}, 1'b1, '{7'd98, 7'd0,  1'b1, 1'b0}},
    '{'{rda_pkg::OP_ADD, 7'd0,   7'd0,   7'd0,   1'b0}, 1'b1, '{7'd1,  7'd0,  1'b0, 1'b0}},
    '{'{rda_pkg::OP_SUB, 7'd0,   7'd99,  7'd0,   1'b1}, 1'b1, '{7'd1,  7'd0,  1'b1, 1'b0}},
    '{'{rda_pkg::OP_SUB, 7'd0,   7'd0,   7'd0,   1'b0}, 1'b1, '{7'd99, 7'd0,  1'b1, 1'b0}},
    '{'{rda_pkg::OP_MUL, 7'd99,  7'd99,  7'd0,   1'b0}, 1'b1, '{7'd1,  7'd98, 1'b1, 1'b0}},
    '{'{rda_pkg::OP_DIV, 7'd3,   7'd0,   7'd5,   1'b0}, 1'b1, '{7'd0,  7'd0,  1'b1, 1'b1}},
    '{'{rda_pkg::OP_DIV, 7'd3,   7'd50,  7'd50,  1'b1}, 1'b1, '{7'd0,  7'd0,  1'b0, 1'b1}},
    '{'{rda_pkg::OP_DIV, 7'd99,  7'd100, 7'd99,  1'b0}, 1'b1, '{7'd99, 7'd99, 1'b0, 1'b0}},
    '{'{rda_pkg::OP_DIV, 7'd127, 7'd127, 7'd127, 1'b0}, 1'b1, '{7'd0,  7'd0,  1'b0, 1'b1}},
    '{'{rda_pkg::OP_SUB, 7'd99,  7'd0,   7'd0,   1'b1}, 1'b1, '{7'd99, 7'd0,  1'b0, 1'b0}},
    '{'{rda_pkg::OP_ADD, 7'd127, 7'd127, 7'd0,   1'b0}, 1'b0, '0},
    '{'{rda_pkg::OP_MUL, 7'd127, 7'd127, 7'd0,   1'b1}, 1'b0, '0},
    '{'{rda_pkg::OP_SUB, 7'd127, 7'd0,   7'd0,   1'b0}, 1'b0, '0},
    '{'{rda_pkg::OP_SUB, 7'd0,   7'd127, 7'd0,   1'b0}, 1'b0, '0},
    '{'{rda_pkg::OP_DIV, 7'd0,   7'd1,   7'd0,   1'b0}, 1'b0, '0},
    '{'{rda_pkg::OP_DIV, 7'd99,  7'd99,  7'd98,  1'b0}, 1'b0, '0},
    '{'{rda_pkg::OP_DIV, 7'd0,   7'd99,  7'd99,  1'b0}, 1'b0, '0},
    '{'{rda_pkg::OP_MUL, 7'd0,   7'd127, 7'd127, 1'b0}, 1'b0, '0},
    '{'{rda_pkg::OP_ADD, 7'd0,   7'd0,   7'd127, 1'b1}, 1'b0, '0},
    '{'{rda_pkg::OP_DIV, 7'd85,  7'd42,  7'd42,  1'b1}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  rda_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rda_pkg::rsp_t rsp;

  logic carry_model = 1'b0;
  rda_pkg::rsp_t rsp_due[$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  radix_digit_alu_core #(.DIGIT_BASE(DIGIT_BASE)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic rda_pkg::rsp_t alu_digit_math(input rda_pkg::req_t r);
    rda_pkg::rsp_t o;
    int a, b, hi, t, m;
    o = '0;
    a = r.operand_a;
    b = r.operand_b;
    hi = r.operand_high;
    if (r.clear_carry) carry_model = 1'b0;
    case (rda_pkg::op_t'(r.req_type))
      rda_pkg::OP_ADD: begin
        t = a + b + carry_model;
        o.digit_result = 7'(t % DIGIT_BASE);
        carry_model = (t >= DIGIT_BASE);
      end
      rda_pkg::OP_SUB: begin
        t = a - b - carry_model;
        m = t % DIGIT_BASE;
        if (m < 0) m += DIGIT_BASE;
        o.digit_result = 7'(m);
        carry_model = (t < 0);
      end
      rda_pkg::OP_MUL: begin
        t = a * b;
        o.digit_result = 7'(t % DIGIT_BASE);
        o.digit_extra = 7'((t / DIGIT_BASE) % DIGIT_BASE);
      end
      default: begin
        t = hi * DIGIT_BASE + a;
        if (b == 0 || t / b >= DIGIT_BASE) begin
          o.error = 1'b1;
        end else begin
          o.digit_extra = 7'(t / b);
          o.digit_result = 7'(t % b);
        end
      end
    endcase
    o.carry_out = carry_model;
    return o;
  endfunction

  function automatic logic [6:0] pick_digit();
    return ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(99));
  endfunction

  function automatic rda_pkg::req_t random_op();
    rda_pkg::req_t r;
    int lim;
    r.req_type = 2'($urandom_range(3));
    r.operand_a = pick_digit();
    r.operand_b = pick_digit();
    r.operand_high = pick_digit();
    r.clear_carry = ($urandom_range(3) == 0);
    // Keep most divides in range: high digit below the divisor.
    if (rda_pkg::op_t'(r.req_type) == rda_pkg::OP_DIV && $urandom_range(9) < 7) begin
      if (r.operand_b == 0) r.operand_b = 7'd1;
      lim = (r.operand_b > 100) ? 100 : r.operand_b;
      r.operand_high = 7'($urandom_range(lim - 1));
    end
    return r;
  endfunction

  task automatic push_op(input rda_pkg::req_t r, input logic known, input rda_pkg::rsp_t want);
    rda_pkg::rsp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(negedge clk); while (req_stall);
    p = alu_digit_math(r);
    rsp_due.push_back(known ? want : p);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    rsp_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Sample mid-cycle: the beat is taken at the next rising edge.
  always @(negedge clk) begin
    rda_pkg::rsp_t w;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due.size() == 0) begin
        $error("unexpected result beat: %p", rsp);
        mismatches++;
      end else begin
        w = rsp_due.pop_front();
        if (rsp.digit_result !== w.digit_result) begin
          $error("digit_result: expected %0d, got %0d", w.digit_result, rsp.digit_result);
          mismatches++;
        end
        if (rsp.digit_extra !== w.digit_extra) begin
          $error("digit_extra: expected %0d, got %0d", w.digit_extra, rsp.digit_extra);
          mismatches++;
        end
        if (rsp.carry_out !== w.carry_out) begin
          $error("carry_out: expected %0d, got %0d", w.carry_out, rsp.carry_out);
          mismatches++;
        end
        if (rsp.error !== w.error) begin
          $error("error: expected %0d, got %0d", w.error, rsp.error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) push_op(DIRECTED[i].op, DIRECTED[i].known, DIRECTED[i].want);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct <= 70;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 70;
        end
        default: begin
          send_idle_pct <= 29;
          recv_stall_pct <= 29;
        end
      endcase
      repeat (375) push_op(random_op(), 1'b0, '0);
    end
    req_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && rsp_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

endmodule
